FILE: rtl/core/sfd_pkg.sv
// Shared types, codes and constants of the sync frame deframer.
`default_nettype none

package sfd_pkg;

	// Frame layout: sixteen data bytes, then checksum and footer.
	localparam int unsigned DATA_LEN    = 16;
	localparam int unsigned PAYLOAD_LEN = 18;
	localparam int unsigned DATA_IW     = $clog2(DATA_LEN);
	localparam int unsigned IDX_W       = 5;
	localparam int unsigned WORD_W      = 32;
	localparam int unsigned FRAME_W     = DATA_LEN * 8;

	// Default frame store depth.
	localparam int unsigned QUEUE_DEPTH_DEF = 16;

	// Register reset values.
	localparam logic [7:0] SYNC_FIRST_RST   = 8'd170;
	localparam logic [7:0] SYNC_SECOND_RST  = 8'd85;
	localparam logic [7:0] FOOTER_VALUE_RST = 8'd0;

	// Field widths on the channels.
	localparam int unsigned CMD_W    = 2;
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned COUNT_W  = 5;
	localparam int unsigned CFG_IW   = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_FEED  = 2'd0,
		CMD_POP   = 2'd1,
		CMD_FLUSH = 2'd2,
		CMD_DROP  = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_NONE     = 3'd0,
		ST_PUSHED   = 3'd1,
		ST_BAD_CHK  = 3'd2,
		ST_BAD_FOOT = 3'd3,
		ST_DROPPED  = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		PH_SEEK0   = 2'd0,
		PH_SEEK1   = 2'd1,
		PH_COLLECT = 2'd2
	} phase_t;

	typedef enum logic [CFG_IW-1:0] {
		REG_SYNC_FIRST   = 2'd0,
		REG_SYNC_SECOND  = 2'd1,
		REG_FOOTER_VALUE = 2'd2
	} cfg_reg_t;

	// One result beat as held in the output registers.
	typedef struct packed {
		logic                pop_valid;
		logic [WORD_W-1:0]   angle_word_0;
		logic [WORD_W-1:0]   angle_word_1;
		logic [WORD_W-1:0]   angle_word_2;
		logic [WORD_W-1:0]   angle_word_3;
		logic [STATUS_W-1:0] frame_status;
		logic [COUNT_W-1:0]  queue_count;
		logic                queue_full;
		logic                queue_empty;
		logic                drop_seen;
	} result_t;

endpackage

`default_nettype wire

FILE: rtl/core/sfd_if.sv
// Channel interfaces of the sync frame deframer: commands, results and configuration.
`default_nettype none

interface sfd_req_if import sfd_pkg::*;;
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  cmd;
	logic [BYTE_W-1:0] data_byte;

	modport source (output valid, output cmd, output data_byte, input ready);
	modport sink (input valid, input cmd, input data_byte, output ready);
endinterface

interface sfd_rsp_if import sfd_pkg::*;;
	logic                valid;
	logic                ready;
	logic                pop_valid;
	logic [WORD_W-1:0]   angle_word_0;
	logic [WORD_W-1:0]   angle_word_1;
	logic [WORD_W-1:0]   angle_word_2;
	logic [WORD_W-1:0]   angle_word_3;
	logic [STATUS_W-1:0] frame_status;
	logic [COUNT_W-1:0]  queue_count;
	logic                queue_full;
	logic                queue_empty;
	logic                drop_seen;

	modport source (
		output valid, output pop_valid, output angle_word_0, output angle_word_1,
		output angle_word_2, output angle_word_3, output frame_status,
		output queue_count, output queue_full, output queue_empty, output drop_seen,
		input ready
	);
	modport sink (
		input valid, input pop_valid, input angle_word_0, input angle_word_1,
		input angle_word_2, input angle_word_3, input frame_status,
		input queue_count, input queue_full, input queue_empty, input drop_seen,
		output ready
	);
endinterface

interface sfd_cfg_if import sfd_pkg::*;;
	logic              valid;
	logic              ready;
	logic [CFG_IW-1:0] index;
	logic [BYTE_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/sync_frame_deframer_fifo.sv
// Sync-header frame deframer with XOR checksum check and a frame FIFO.
//
// Each command beat on req (feed a byte, pop a frame, flush, read and clear the
// drop flag) gives exactly one result beat on rsp. The block takes one beat every
// cycle while the skid register is empty: all work for a beat is done in the
// cycle it is accepted, and the result is registered in the output register, or,
// while a result still waits on rsp, in the skid register behind it, which lets
// the block take that beat; req.ready only drops when both are full. Frames are
// held in a QUEUE_DEPTH x 128-bit memory with one write and one read port; the
// head entry is kept prefetched in a register so a pop returns its words without
// a stall. The memory is not cleared after reset and needs no clearing pass.
// Configuration writes on cfg are always taken and apply from the next cycle.
`default_nettype none

module sync_frame_deframer_fifo import sfd_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	sfd_req_if.sink    req,
	sfd_rsp_if.source  rsp,
	sfd_cfg_if.sink    cfg
);

	localparam int unsigned PW = $clog2(QUEUE_DEPTH);
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

	// Configuration registers.
	logic [BYTE_W-1:0] sync_first_q;
	logic [BYTE_W-1:0] sync_second_q;
	logic [BYTE_W-1:0] footer_value_q;

	// Parser state.
	phase_t           phase_q, phase_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic             frame_end;

	// Frame assembly.
	logic [BYTE_W-1:0]  data_q [DATA_LEN];
	logic [BYTE_W-1:0]  xor_q, xor_d;
	logic               chk_bad_q, chk_bad_d;
	logic               byte_we;
	logic [FRAME_W-1:0] wr_data;

	// Frame store.
	logic [FRAME_W-1:0] mem [QUEUE_DEPTH];
	logic [FRAME_W-1:0] head_q;
	logic [PW-1:0]      rp_q, rp_d, wp_q, wp_d;
	logic [CW-1:0]      cnt_q, cnt_d;
	logic               drop_q, drop_d;
	logic               push, pop;

	// Output registers with skid.
	result_t main_q, skid_q, res;
	logic    main_valid_q, skid_valid_q;

	logic acc, out_fire, full;
	cmd_t cmd;

	assign acc      = req.valid && req.ready;
	assign out_fire = main_valid_q && rsp.ready;
	assign cmd      = cmd_t'(req.cmd);
	assign full     = (cnt_q == CW'(QUEUE_DEPTH));

	assign req.ready = !skid_valid_q;
	assign cfg.ready = 1'b1;

	// Configuration writes; indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q   <= SYNC_FIRST_RST;
			sync_second_q  <= SYNC_SECOND_RST;
			footer_value_q <= FOOTER_VALUE_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg_reg_t'(cfg.index))
				REG_SYNC_FIRST:   sync_first_q   <= cfg.data;
				REG_SYNC_SECOND:  sync_second_q  <= cfg.data;
				REG_FOOTER_VALUE: footer_value_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Parser next state: sync search, then eighteen collected bytes.
	always_comb begin
		phase_d   = phase_q;
		idx_d     = idx_q;
		frame_end = 1'b0;
		if (acc) begin
			case (cmd)
				CMD_FEED: begin
					case (phase_q)
						PH_SEEK0: begin
							if (req.data_byte == sync_first_q) phase_d = PH_SEEK1;
						end
						PH_SEEK1: begin
							// A repeated first sync byte keeps waiting for the second.
							if (req.data_byte == sync_second_q) begin
								idx_d   = '0;
								phase_d = PH_COLLECT;
							end else if (req.data_byte != sync_first_q) begin
								phase_d = PH_SEEK0;
							end
						end
						PH_COLLECT: begin
							if (idx_q == IDX_W'(PAYLOAD_LEN - 1)) begin
								frame_end = 1'b1;
								phase_d   = PH_SEEK0;
								idx_d     = '0;
							end else begin
								idx_d = idx_q + 1'b1;
							end
						end
						default: phase_d = PH_SEEK0;
					endcase
				end
				CMD_FLUSH: begin
					phase_d = PH_SEEK0;
					idx_d   = '0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEEK0;
			idx_q   <= '0;
		end else begin
			phase_q <= phase_d;
			idx_q   <= idx_d;
		end
	end

	// Running checksum and data byte capture.
	always_comb begin
		xor_d     = xor_q;
		chk_bad_d = chk_bad_q;
		byte_we   = 1'b0;
		if (acc && cmd == CMD_FEED) begin
			if (phase_q == PH_SEEK1) begin
				xor_d = '0;
			end else if (phase_q == PH_COLLECT) begin
				if (idx_q < IDX_W'(DATA_LEN)) begin
					byte_we = 1'b1;
					xor_d   = xor_q ^ req.data_byte;
				end else if (idx_q == IDX_W'(DATA_LEN)) begin
					chk_bad_d = (xor_q != req.data_byte);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		xor_q     <= xor_d;
		chk_bad_q <= chk_bad_d;
		if (byte_we) data_q[idx_q[DATA_IW-1:0]] <= req.data_byte;
	end

	// Data bytes packed little-endian into four words.
	always_comb begin
		for (int k = 0; k < DATA_LEN; k++) begin
			wr_data[8*k +: 8] = data_q[k];
		end
	end

	// FIFO control, frame status and drop flag.
	always_comb begin
		rp_d   = rp_q;
		wp_d   = wp_q;
		cnt_d  = cnt_q;
		drop_d = drop_q;
		push   = 1'b0;
		pop    = 1'b0;
		res    = '0;
		if (acc) begin
			case (cmd)
				CMD_FEED: begin
					if (frame_end) begin
						// Checksum error wins over footer error.
						if (chk_bad_q) begin
							res.frame_status = ST_BAD_CHK;
						end else if (req.data_byte != footer_value_q) begin
							res.frame_status = ST_BAD_FOOT;
						end else if (full) begin
							res.frame_status = ST_DROPPED;
							drop_d           = 1'b1;
						end else begin
							res.frame_status = ST_PUSHED;
							push             = 1'b1;
							wp_d  = (wp_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
							cnt_d = cnt_q + 1'b1;
						end
					end
					res.drop_seen = drop_d;
				end
				CMD_POP: begin
					if (cnt_q != '0) begin
						pop           = 1'b1;
						res.pop_valid = 1'b1;
						rp_d  = (rp_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_q + 1'b1;
						cnt_d = cnt_q - 1'b1;
					end
					res.drop_seen = drop_d;
				end
				CMD_FLUSH: begin
					rp_d          = '0;
					wp_d          = '0;
					cnt_d         = '0;
					drop_d        = 1'b0;
					res.drop_seen = 1'b0;
				end
				CMD_DROP: begin
					res.drop_seen = drop_q;
					drop_d        = 1'b0;
				end
				default: ;
			endcase
		end
		if (pop) begin
			res.angle_word_0 = head_q[0*WORD_W +: WORD_W];
			res.angle_word_1 = head_q[1*WORD_W +: WORD_W];
			res.angle_word_2 = head_q[2*WORD_W +: WORD_W];
			res.angle_word_3 = head_q[3*WORD_W +: WORD_W];
		end
		res.queue_count = COUNT_W'(cnt_d);
		res.queue_full  = (cnt_d == CW'(QUEUE_DEPTH));
		res.queue_empty = (cnt_d == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q   <= '0;
			wp_q   <= '0;
			cnt_q  <= '0;
			drop_q <= 1'b0;
		end else begin
			rp_q   <= rp_d;
			wp_q   <= wp_d;
			cnt_q  <= cnt_d;
			drop_q <= drop_d;
		end
	end

	// Frame store; the head entry is fetched ahead, with a bypass when the
	// frame being written lands at the next head address.
	always_ff @(posedge clk) begin
		if (push) mem[wp_q] <= wr_data;
		head_q <= (push && wp_q == rp_d) ? wr_data : mem[rp_d];
	end

	// Output register and skid register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!main_valid_q || out_fire) begin
			if (skid_valid_q) begin
				main_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				main_valid_q <= acc;
			end
		end else if (acc) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!main_valid_q || out_fire) begin
			if (skid_valid_q) main_q <= skid_q;
			else if (acc) main_q <= res;
		end else if (acc) begin
			skid_q <= res;
		end
	end

	// Result beat on rsp.
	assign rsp.valid        = main_valid_q;
	assign rsp.pop_valid    = main_q.pop_valid;
	assign rsp.angle_word_0 = main_q.angle_word_0;
	assign rsp.angle_word_1 = main_q.angle_word_1;
	assign rsp.angle_word_2 = main_q.angle_word_2;
	assign rsp.angle_word_3 = main_q.angle_word_3;
	assign rsp.frame_status = main_q.frame_status;
	assign rsp.queue_count  = main_q.queue_count;
	assign rsp.queue_full   = main_q.queue_full;
	assign rsp.queue_empty  = main_q.queue_empty;
	assign rsp.drop_seen    = main_q.drop_seen;

endmodule

`default_nettype wire

FILE: rtl/core/sfd_checker.sv
// Port-level checker for the sync frame deframer, bound to the top level.
`default_nettype none

module sfd_checker import sfd_pkg::*; (
	input wire                clk,
	input wire                arst_n,
	input wire                req_valid,
	input wire                req_ready,
	input wire                rsp_valid,
	input wire                rsp_ready,
	input wire                rsp_pop_valid,
	input wire [WORD_W-1:0]   rsp_word_0,
	input wire [STATUS_W-1:0] rsp_status,
	input wire [COUNT_W-1:0]  rsp_count,
	input wire                rsp_empty
);

	// Beats accepted on req whose result beat has not yet left on rsp.
	logic [1:0] open_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
		end else begin
			open_q <= open_q + 2'((req_valid && req_ready) ? 1 : 0)
				- 2'((rsp_valid && rsp_ready) ? 1 : 0);
		end
	end

	// A stalled result beat stays valid and keeps its pop flag, first word, status and count.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pop_valid)
			&& $stable(rsp_word_0) && $stable(rsp_status) && $stable(rsp_count))
		else $error("result beat changed while stalled");

	// Every result beat answers an earlier command beat.
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> open_q != 2'd0)
		else $error("result beat without a pending command");

	// At most two results wait: the output register and the skid register.
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		open_q == 2'd2 |-> !req_ready)
		else $error("command taken with both result registers full");

	// A pushed frame leaves the queue nonempty.
	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_PUSHED |-> !rsp_empty)
		else $error("push reported with an empty queue");

endmodule

bind sync_frame_deframer_fifo sfd_checker u_sfd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_pop_valid (rsp.pop_valid),
	.rsp_word_0    (rsp.angle_word_0),
	.rsp_status    (rsp.frame_status),
	.rsp_count     (rsp.queue_count),
	.rsp_empty     (rsp.queue_empty)
);

`default_nettype wire

FILE: test/sync_frame_deframer_fifo_test.sv
// Self-checking testbench for the sync frame deframer with its frame FIFO.
module sync_frame_deframer_fifo_test;
	import sfd_pkg::*;

	localparam int unsigned DEPTH       = QUEUE_DEPTH_DEF;
	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam int unsigned HOLD_CYCLES = 200;

	typedef struct {
		cmd_t       cmd;
		logic [7:0] data;
	} req_beat_t;

	logic clk;
	logic arst_n;

	sfd_req_if req ();
	sfd_rsp_if rsp ();
	sfd_cfg_if cfg ();

	sync_frame_deframer_fifo #(.QUEUE_DEPTH(DEPTH)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	// Free-running clock, period 4.
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Command beats waiting to be sent and result beats waiting to arrive.
	req_beat_t cmd_backlog[$];
	result_t   pending_results[$];

	// Shadow copy of the deframer: registers, parser, frame store and flags.
	logic [7:0]  cfg_first  = SYNC_FIRST_RST;
	logic [7:0]  cfg_second = SYNC_SECOND_RST;
	logic [7:0]  cfg_footer = FOOTER_VALUE_RST;
	phase_t      parse_ph   = PH_SEEK0;
	logic [7:0]  frame_bytes [PAYLOAD_LEN];
	int unsigned byte_cnt   = 0;
	logic [31:0] frame_words [DEPTH][4];
	int unsigned rd_ptr     = 0;
	int unsigned wr_ptr     = 0;
	int unsigned held       = 0;
	bit          drop_flag  = 1'b0;

	// Run bookkeeping.
	int unsigned errors        = 0;
	int unsigned cycles        = 0;
	int unsigned beats_queued  = 0;
	int unsigned beats_checked = 0;
	int unsigned phases_run    = 0;
	int unsigned stat_pushed   = 0;
	int unsigned stat_dropped  = 0;
	int unsigned stat_bad_chk  = 0;
	int unsigned stat_bad_foot = 0;
	int unsigned stat_popped   = 0;
	int unsigned stat_flushes  = 0;

	// Handshake pacing.
	bit          no_idle   = 1'b0;
	bit          req_taken = 1'b0;
	int unsigned send_gap  = 0;
	int unsigned rsp_wait  = 0;
	int unsigned hold_left = 0;

	// Advance the shadow deframer by one command beat and return its result beat.
	function automatic result_t deframe_step(cmd_t c, logic [7:0] b);
		result_t    r;
		logic [7:0] sum;
		status_t    st;
		r = '0;
		case (c)
			CMD_FEED: begin
				case (parse_ph)
					PH_SEEK0: begin
						if (b == cfg_first)
							parse_ph = PH_SEEK1;
					end
					PH_SEEK1: begin
						// A repeated first sync byte keeps the parser waiting.
						if (b == cfg_second) begin
							byte_cnt = 0;
							parse_ph = PH_COLLECT;
						end else if (b != cfg_first) begin
							parse_ph = PH_SEEK0;
						end
					end
					default: begin
						frame_bytes[byte_cnt] = b;
						byte_cnt++;
						if (byte_cnt == PAYLOAD_LEN) begin
							// Checksum is judged before the footer, then room in the store.
							sum = '0;
							for (int i = 0; i < DATA_LEN; i++)
								sum ^= frame_bytes[i];
							if (sum != frame_bytes[DATA_LEN]) begin
								st = ST_BAD_CHK;
								stat_bad_chk++;
							end else if (frame_bytes[PAYLOAD_LEN-1] != cfg_footer) begin
								st = ST_BAD_FOOT;
								stat_bad_foot++;
							end else if (held >= DEPTH) begin
								st = ST_DROPPED;
								drop_flag = 1'b1;
								stat_dropped++;
							end else begin
								for (int k = 0; k < 4; k++)
									frame_words[wr_ptr][k] = {frame_bytes[4*k+3],
										frame_bytes[4*k+2], frame_bytes[4*k+1],
										frame_bytes[4*k]};
								wr_ptr = (wr_ptr + 1) % DEPTH;
								held++;
								st = ST_PUSHED;
								stat_pushed++;
							end
							r.frame_status = st;
							parse_ph = PH_SEEK0;
							byte_cnt = 0;
						end
					end
				endcase
			end
			CMD_POP: begin
				if (held != 0) begin
					r.pop_valid    = 1'b1;
					r.angle_word_0 = frame_words[rd_ptr][0];
					r.angle_word_1 = frame_words[rd_ptr][1];
					r.angle_word_2 = frame_words[rd_ptr][2];
					r.angle_word_3 = frame_words[rd_ptr][3];
					rd_ptr = (rd_ptr + 1) % DEPTH;
					held--;
					stat_popped++;
				end
			end
			CMD_FLUSH: begin
				parse_ph  = PH_SEEK0;
				byte_cnt  = 0;
				rd_ptr    = 0;
				wr_ptr    = 0;
				held      = 0;
				drop_flag = 1'b0;
				stat_flushes++;
			end
			default: ;
		endcase
		// The drop-flag read reports the flag as it was before clearing it.
		r.drop_seen = drop_flag;
		if (c == CMD_DROP)
			drop_flag = 1'b0;
		r.queue_count = held[COUNT_W-1:0];
		r.queue_full  = (held >= DEPTH);
		r.queue_empty = (held == 0);
		return r;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			errors++;
		end
	endfunction

	// Predict on every accepted command beat.
	always @(posedge clk) begin
		req_taken = req.valid && req.ready;
		if (req_taken)
			pending_results.push_back(deframe_step(cmd_t'(req.cmd), req.data_byte));
	end

	// Drive command beats from the backlog, with a random gap after each one unless no_idle is set.
	always @(negedge clk) begin : drive_req
		req_beat_t nxt;
		if (arst_n && !(req.valid && !req_taken)) begin
			if (send_gap != 0) begin
				send_gap--;
				req.valid <= 1'b0;
			end else if (cmd_backlog.size() != 0) begin
				nxt = cmd_backlog.pop_front();
				req.valid     <= 1'b1;
				req.cmd       <= nxt.cmd;
				req.data_byte <= nxt.data;
				send_gap = no_idle ? 0 : $urandom_range(0, 11);
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	// Check each result beat against the oldest prediction.
	always @(posedge clk) begin : check_rsp
		result_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result beat arrived with nothing expected", $time);
				errors++;
			end else begin
				want = pending_results.pop_front();
				check_field("pop_valid", 32'(want.pop_valid), 32'(rsp.pop_valid));
				check_field("angle_word_0", want.angle_word_0, rsp.angle_word_0);
				check_field("angle_word_1", want.angle_word_1, rsp.angle_word_1);
				check_field("angle_word_2", want.angle_word_2, rsp.angle_word_2);
				check_field("angle_word_3", want.angle_word_3, rsp.angle_word_3);
				check_field("frame_status", 32'(want.frame_status), 32'(rsp.frame_status));
				check_field("queue_count", 32'(want.queue_count), 32'(rsp.queue_count));
				check_field("queue_full", 32'(want.queue_full), 32'(rsp.queue_full));
				check_field("queue_empty", 32'(want.queue_empty), 32'(rsp.queue_empty));
				check_field("drop_seen", 32'(want.drop_seen), 32'(rsp.drop_seen));
				beats_checked++;
			end
			rsp_wait = no_idle ? 0 : $urandom_range(0, 11);
		end
	end

	// Result-side ready: long hold-off first, then the per-beat stall.
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left != 0) begin
				rsp.ready <= 1'b0;
			end else if (rsp_wait != 0) begin
				rsp_wait--;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	// Count down a long receiver hold-off.
	always @(posedge clk) begin
		if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
			$display("** sync_frame_deframer_fifo: FAILED **");
			$finish;
		end
	end

	task automatic queue_beat(input cmd_t c, input logic [7:0] b);
		req_beat_t nb;
		nb.cmd  = c;
		nb.data = b;
		cmd_backlog.push_back(nb);
		beats_queued++;
	endtask

	// Queue a whole frame: sync pair, data, checksum and footer, optionally corrupted.
	task automatic push_frame(input logic [7:0] payload [DATA_LEN], input bit bad_chk,
			input bit bad_foot);
		logic [7:0] sum;
		sum = '0;
		queue_beat(CMD_FEED, cfg_first);
		queue_beat(CMD_FEED, cfg_second);
		for (int i = 0; i < DATA_LEN; i++) begin
			queue_beat(CMD_FEED, payload[i]);
			sum ^= payload[i];
		end
		queue_beat(CMD_FEED, bad_chk ? sum ^ 8'($urandom_range(1, 255)) : sum);
		queue_beat(CMD_FEED, bad_foot ? cfg_footer ^ 8'($urandom_range(1, 255)) : cfg_footer);
	endtask

	// Mostly well-formed frames with random content, mixed with commands and noise.
	task automatic random_beats(input int unsigned n_beats, input int unsigned pop_pct);
		int unsigned stop_at;
		int unsigned pick;
		int unsigned cut;
		logic [7:0]  payload [DATA_LEN];
		stop_at = beats_queued + n_beats;
		while (beats_queued < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < pop_pct) begin
				queue_beat(CMD_POP, 8'($urandom));
			end else if (pick < pop_pct + 2) begin
				queue_beat(CMD_FLUSH, 8'($urandom));
			end else if (pick < pop_pct + 6) begin
				queue_beat(CMD_DROP, 8'($urandom));
			end else if (pick < pop_pct + 13) begin
				repeat ($urandom_range(1, 3))
					queue_beat(CMD_FEED, 8'($urandom));
			end else if (pick < pop_pct + 17) begin
				// Frame cut short, sometimes cleaned up by a flush.
				cut = $urandom_range(0, PAYLOAD_LEN - 1);
				queue_beat(CMD_FEED, cfg_first);
				queue_beat(CMD_FEED, cfg_second);
				repeat (cut)
					queue_beat(CMD_FEED, 8'($urandom));
				if ($urandom_range(0, 1))
					queue_beat(CMD_FLUSH, 8'($urandom));
			end else begin
				pick = $urandom_range(0, 9);
				for (int i = 0; i < DATA_LEN; i++)
					payload[i] = (pick == 0) ? 8'hFF : (pick == 1) ? 8'h00 : 8'($urandom);
				if ($urandom_range(0, 7) == 0)
					queue_beat(CMD_FEED, cfg_first);
				cut = $urandom_range(0, 15);
				push_frame(payload, cut == 0 || cut == 2, cut == 1 || cut == 2);
			end
		end
	endtask

	// Wait until every queued beat has been sent and every result checked.
	task automatic wait_drained();
		do
			@(posedge clk);
		while (cmd_backlog.size() != 0 || req.valid || pending_results.size() != 0);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [7:0] val);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= val;
		do
			@(posedge clk);
		while (!cfg.ready);
		case (idx)
			REG_SYNC_FIRST:  cfg_first  = val;
			REG_SYNC_SECOND: cfg_second = val;
			default:         cfg_footer = val;
		endcase
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	// One register setting followed by an optional store overfill and a block of random traffic.
	task automatic run_phase(input logic [7:0] first, input logic [7:0] second,
			input logic [7:0] footer, input int unsigned n_beats, input int unsigned pop_pct,
			input bit busy, input bit fill_and_hold, input bit pause_mid);
		logic [7:0] payload [DATA_LEN];
		wait_drained();
		write_reg(REG_SYNC_FIRST, first);
		write_reg(REG_SYNC_SECOND, second);
		write_reg(REG_FOOTER_VALUE, footer);
		no_idle = busy;
		phases_run++;
		// Overfill the store so frames get dropped, while the receiver holds off.
		if (fill_and_hold) begin
			repeat (DEPTH + 2) begin
				for (int i = 0; i < DATA_LEN; i++)
					payload[i] = 8'($urandom);
				push_frame(payload, 1'b0, 1'b0);
			end
			@(negedge clk);
			hold_left = HOLD_CYCLES;
		end
		random_beats(n_beats / 2, pop_pct);
		if (pause_mid)
			wait_drained();
		random_beats(n_beats - n_beats / 2, pop_pct);
	endtask

	initial begin : stimulus
		logic [7:0] payload [DATA_LEN];
		arst_n        = 1'b0;
		req.valid     = 1'b0;
		req.cmd       = CMD_FEED;
		req.data_byte = '0;
		rsp.ready     = 1'b0;
		cfg.valid     = 1'b0;
		cfg.index     = REG_SYNC_FIRST;
		cfg.data      = '0;
		for (int i = 0; i < PAYLOAD_LEN; i++)
			frame_bytes[i] = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: pop and flag read on an empty store, a stray byte, then a frame
		// behind a repeated first sync byte with extreme data, popped back out.
		queue_beat(CMD_POP, 8'h00);
		queue_beat(CMD_DROP, 8'hFF);
		queue_beat(CMD_FEED, 8'h00);
		queue_beat(CMD_FEED, cfg_first);
		for (int i = 0; i < DATA_LEN; i++)
			payload[i] = (i % 2) ? 8'hFF : 8'h00;
		payload[0]            = 8'h01;
		payload[DATA_LEN - 1] = 8'h80;
		push_frame(payload, 1'b0, 1'b0);
		queue_beat(CMD_POP, 8'h5A);
		phases_run++;

		// Random phases over several register settings, extremes included.
		run_phase(SYNC_FIRST_RST, SYNC_SECOND_RST, FOOTER_VALUE_RST, 250, 30, 1'b0, 1'b0, 1'b0);
		run_phase(8'h00, 8'h00, 8'h00, 250, 5, 1'b1, 1'b1, 1'b0);
		run_phase(8'hFF, 8'hFF, 8'hFF, 250, 50, 1'b0, 1'b0, 1'b1);
		run_phase(8'hFF, 8'h00, 8'h80, 250, 20, 1'b0, 1'b0, 1'b0);
		run_phase(8'($urandom), 8'($urandom), 8'($urandom), 250, 35, 1'b1, 1'b0, 1'b0);
		run_phase(8'($urandom), 8'($urandom), 8'($urandom), 250, 25, 1'b0, 1'b0, 1'b0);
		wait_drained();

		$display("Checked %0d result beats over %0d register settings, with %0d pops and %0d flushes.",
			beats_checked, phases_run, stat_popped, stat_flushes);
		$display("Frames: %0d stored, %0d dropped on a full store, %0d bad checksum, %0d bad footer.",
			stat_pushed, stat_dropped, stat_bad_chk, stat_bad_foot);
		if (errors == 0)
			$display("** sync_frame_deframer_fifo: PASSED **");
		else
			$display("** sync_frame_deframer_fifo: FAILED **");
		$finish;
	end

endmodule
